// ===== rtl/core/lphs_pkg.sv =====
// ----------------------------------------------------------------------------
// lphs_pkg: shared types and codes for the linear probe hash set
// Opcodes, status codes, field widths and the table write command.
// ----------------------------------------------------------------------------
package lphs_pkg;

   localparam int OP_W     = 2;
   localparam int KEY_W    = 32;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;

   localparam int DEF_SLOTS = 16;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

   typedef struct packed {
      logic occupied;
      logic deleted;
   } lphs_flags_type;

   typedef struct packed {
      logic           key_en;
      logic           flag_en;
      lphs_flags_type flags;
   } lphs_wr_type;

endpackage

// ===== rtl/core/lphs_if.sv =====
// ----------------------------------------------------------------------------
// lphs_if: request and response channels of the hash set
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lphs_req_if;
   import lphs_pkg::*;

   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  opcode;
   logic [KEY_W-1:0] key;

   modport source (output valid, output opcode, output key, input ready);
   modport sink   (input valid, input opcode, input key, output ready);
endinterface

interface lphs_rsp_if;
   import lphs_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot;

   modport source (output valid, output status, output slot, input ready);
   modport sink   (input valid, input status, input slot, output ready);
endinterface

// ===== rtl/core/lphs_mod_unit.sv =====
// ----------------------------------------------------------------------------
// lphs_mod_unit: key modulo slot count
// Reciprocal multiply for the quotient, multiply back and subtract.
// ----------------------------------------------------------------------------
module lphs_mod_unit #(
   parameter int SLOTS = lphs_pkg::DEF_SLOTS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [lphs_pkg::KEY_W-1:0]     dividend,
   output logic                           done,
   output logic [$clog2(SLOTS)-1:0]       remainder
);
   import lphs_pkg::*;

   localparam int SW = $clog2(SLOTS);
   localparam int PW = 2 * KEY_W;

   // ceil(2^(KEY_W+SW) / SLOTS), at most KEY_W+1 bits
   localparam logic [PW:0] RECIP =
      (((PW+1)'(1) << (KEY_W + SW)) + (PW+1)'(SLOTS - 1)) / (PW+1)'(SLOTS);
   localparam logic [KEY_W-1:0] RECIP_LO = RECIP[KEY_W-1:0];
   localparam logic             RECIP_HI = RECIP[KEY_W];

   localparam logic [1:0] STEP_MUL  = 2'd0;
   localparam logic [1:0] STEP_QUOT = 2'd1;
   localparam logic [1:0] STEP_BACK = 2'd2;
   localparam logic [1:0] STEP_REM  = 2'd3;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [1:0]        step_ff, step_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [PW-1:0]     prod_ff, prod_in;
   logic [KEY_W-1:0]  quo_ff, quo_in;
   logic [KEY_W-1:0]  back_ff, back_in;
   logic [SW-1:0]     rem_ff, rem_in;
   logic [PW:0]       scaled;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      key_in  = key_ff;
      prod_in = prod_ff;
      quo_in  = quo_ff;
      back_in = back_ff;
      rem_in  = rem_ff;
      scaled  = {1'b0, prod_ff} + (RECIP_HI ? {1'b0, key_ff, KEY_W'(0)} : '0);
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_MUL;
         key_in  = dividend;
      end else if (busy_ff) begin
         unique case (step_ff)
            STEP_MUL: begin
               prod_in = PW'(key_ff) * PW'(RECIP_LO);
               step_in = STEP_QUOT;
            end
            STEP_QUOT: begin
               quo_in  = KEY_W'(scaled >> (KEY_W + SW));
               step_in = STEP_BACK;
            end
            STEP_BACK: begin
               back_in = quo_ff * KEY_W'(SLOTS);
               step_in = STEP_REM;
            end
            STEP_REM: begin
               rem_in  = SW'(key_ff - back_ff);
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= STEP_MUL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      key_ff  <= key_in;
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      back_ff <= back_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/core/lphs_table.sv =====
// ----------------------------------------------------------------------------
// lphs_table: slot storage
// Key memory and flag memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lphs_table #(
   parameter int SLOTS = lphs_pkg::DEF_SLOTS
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [$clog2(SLOTS)-1:0]     rd_addr,
   output logic [lphs_pkg::KEY_W-1:0]   rd_key,
   output lphs_pkg::lphs_flags_type     rd_flags,
   input  lphs_pkg::lphs_wr_type        wr_cmd,
   input  logic [$clog2(SLOTS)-1:0]     wr_addr,
   input  logic [lphs_pkg::KEY_W-1:0]   wr_key
);
   import lphs_pkg::*;

   logic [KEY_W-1:0] key_mem_ff [SLOTS];
   lphs_flags_type   flag_mem_ff [SLOTS];
   logic [KEY_W-1:0] rd_key_ff;
   lphs_flags_type   rd_flags_ff;

   always_ff @(posedge clock) begin
      if (wr_cmd.key_en) begin
         key_mem_ff[wr_addr] <= wr_key;
      end
      if (wr_cmd.flag_en) begin
         flag_mem_ff[wr_addr] <= wr_cmd.flags;
      end
      if (rd_en) begin
         rd_key_ff   <= key_mem_ff[rd_addr];
         rd_flags_ff <= flag_mem_ff[rd_addr];
      end
   end

   assign rd_key   = rd_key_ff;
   assign rd_flags = rd_flags_ff;

endmodule

// ===== rtl/core/linear_probe_hash_set.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_set: open-addressing hash set with linear probing
// Flow: S_IDLE accepts, S_MOD finds the home slot (reciprocal modulo), each
//    probed slot is read (S_READ) then checked (S_EVAL), S_DONE loads the rsp
//    register. Throughput: one item at a time; the probe loop reads slots
//    through the single table read port. Opcode 3 answers MISS unprobed.
// Reset: a clearing pass writes empty flags to all SLOTS entries with req
//    ready low. Key memory is not cleared.
// ----------------------------------------------------------------------------
module linear_probe_hash_set #(
   parameter int SLOTS = lphs_pkg::DEF_SLOTS
) (
   input  logic       clock,
   input  logic       reset,
   lphs_req_if.sink   req_bus,
   lphs_rsp_if.source rsp_bus
);
   import lphs_pkg::*;

   localparam int SW = $clog2(SLOTS);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_MOD   = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_EVAL  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [SW-1:0]       cur_ff, cur_in;
   logic [SW-1:0]       cnt_ff, cnt_in;
   logic [SW-1:0]       clr_ff, clr_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [SW-1:0]       res_slot_ff, res_slot_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;

   logic                accept;
   logic                mod_start, mod_done;
   logic [SW-1:0]       mod_rem;
   logic                rd_en;
   logic [KEY_W-1:0]    rd_key;
   lphs_flags_type      rd_flags;
   lphs_wr_type         wr_cmd;
   logic [SW-1:0]       wr_addr;
   logic [SW-1:0]       cur_next;
   logic                last_probe;

   lphs_mod_unit #(.SLOTS(SLOTS)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (req_bus.key),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   lphs_table #(.SLOTS(SLOTS)) u_table (
      .clock    (clock),
      .rd_en    (rd_en),
      .rd_addr  (cur_ff),
      .rd_key   (rd_key),
      .rd_flags (rd_flags),
      .wr_cmd   (wr_cmd),
      .wr_addr  (wr_addr),
      .wr_key   (key_ff)
   );

   assign accept     = req_bus.valid && (state_ff == S_IDLE);
   assign cur_next   = (cur_ff == SW'(SLOTS-1)) ? '0 : cur_ff + SW'(1);
   assign last_probe = (cnt_ff == SW'(SLOTS-1));

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      cur_in        = cur_ff;
      cnt_in        = cnt_ff;
      clr_in        = clr_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      mod_start     = 1'b0;
      rd_en         = 1'b0;
      wr_cmd        = '0;
      wr_addr       = cur_ff;

      unique case (state_ff)
         S_CLEAR: begin
            wr_cmd.flag_en = 1'b1;
            wr_addr        = clr_ff;
            clr_in         = clr_ff + SW'(1);
            if (clr_ff == SW'(SLOTS-1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in  = req_bus.opcode;
               key_in = req_bus.key;
               if (req_bus.opcode == OP_UNUSED) begin
                  res_status_in = STAT_MISS;
                  res_slot_in   = '0;
                  state_in      = S_DONE;
               end else begin
                  mod_start = 1'b1;
                  state_in  = S_MOD;
               end
            end
         end
         S_MOD: begin
            if (mod_done) begin
               cur_in   = mod_rem;
               cnt_in   = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            state_in = S_DONE;
            priority if (op_ff == OP_INSERT) begin
               if (!rd_flags.occupied) begin
                  wr_cmd.key_en         = 1'b1;
                  wr_cmd.flag_en        = 1'b1;
                  wr_cmd.flags.occupied = 1'b1;
                  wr_cmd.flags.deleted  = 1'b0;
                  res_status_in         = STAT_OK;
                  res_slot_in           = cur_ff;
               end else if (last_probe) begin
                  res_status_in = STAT_FULL;
                  res_slot_in   = '0;
               end else begin
                  cur_in   = cur_next;
                  cnt_in   = cnt_ff + SW'(1);
                  state_in = S_READ;
               end
            end else begin
               if (rd_flags.occupied && (rd_key == key_ff)) begin
                  if (op_ff == OP_REMOVE) begin
                     wr_cmd.flag_en        = 1'b1;
                     wr_cmd.flags.occupied = 1'b0;
                     wr_cmd.flags.deleted  = 1'b1;
                  end
                  res_status_in = STAT_OK;
                  res_slot_in   = cur_ff;
               end else if ((!rd_flags.occupied && !rd_flags.deleted) || last_probe) begin
                  res_status_in = STAT_MISS;
                  res_slot_in   = '0;
               end else begin
                  cur_in   = cur_next;
                  cnt_in   = cnt_ff + SW'(1);
                  state_in = S_READ;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = SLOT_W'(res_slot_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      cur_ff        <= cur_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign req_bus.ready  = (state_ff == S_IDLE);
   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.status = rsp_status_ff;
   assign rsp_bus.slot   = rsp_slot_ff;

`ifndef SYNTHESIS
   a_eval_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) |-> ($past(state_ff) == S_READ))
      else $error("probe evaluate without preceding read");

   a_miss_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STAT_OK)) |-> (rsp_slot_ff == '0))
      else $error("nonzero slot on failed response");

   a_done_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && (!rsp_valid_ff || rsp_bus.ready)) |=>
      (rsp_valid_ff && (state_ff == S_IDLE)))
      else $error("finished result not loaded into response register");

   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) |-> (cnt_ff <= SW'(SLOTS-1)))
      else $error("probe ran past one lap");
`endif

endmodule
